// ----- sv/rgbmx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB matrix scan driver package
// Shared constants and the command and status groups between the controller
// and the datapath of the LED matrix scan driver.
// ----------------------------------------------------------------------------
package rgbmx_pkg;

   localparam int ROWS_DEFAULT    = 8;
   localparam int COLUMNS_DEFAULT = 24;

   localparam int LEVEL_W       = 3;
   localparam int STEP_W        = 3;
   localparam int GROUP_W       = 8;
   localparam int SHOWN_COLUMNS = 24;

   localparam logic [7:0] DATA_FLAG      = 8'h80;
   localparam logic [7:0] LOW_PIX_MASK   = 8'h07;
   localparam logic [7:0] HIGH_PIX_MASK  = 8'h38;
   localparam logic [7:0] CMD_CLEAR      = 8'hFA;
   localparam logic [7:0] CMD_SHOW       = 8'hFB;
   localparam logic [7:0] ROWS_OFF       = 8'hFF;
   localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic tick_adv;
      logic load_byte;
      logic ptr_clear;
      logic pix_read_wr;
      logic pix_read_sweep;
      logic pix_write;
      logic sel_high;
      logic clear_row;
      logic copy_row;
      logic disp_fetch;
      logic show;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ptr_end;
      logic ptr_last;
      logic sweep_last;
   } status_type;

endpackage

// ----- sv/rgbmx_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB matrix scan driver datapath
// Pixel and display stores, the write pointer, the scan counters and the
// column comparators with the result registers.
// ----------------------------------------------------------------------------
module rgbmx_datapath #(
   parameter int ROWS    = rgbmx_pkg::ROWS_DEFAULT,
   parameter int COLUMNS = rgbmx_pkg::COLUMNS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rgbmx_pkg::cmd_type   cmd,
   output rgbmx_pkg::status_type status,
   input  logic [7:0]           rx_byte,
   output logic                 rsp_strobe,
   output logic [7:0]           rsp_row_drive,
   output logic [7:0]           rsp_col_group0,
   output logic [7:0]           rsp_col_group1,
   output logic [7:0]           rsp_col_group2
);

   localparam int LEVEL_W   = rgbmx_pkg::LEVEL_W;
   localparam int STEP_W    = rgbmx_pkg::STEP_W;
   localparam int ROW_W     = $clog2(ROWS);
   localparam int PTR_ROW_W = $clog2(ROWS + 1);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int LINE_W    = COLUMNS * LEVEL_W;
   localparam int SHOWN     = rgbmx_pkg::SHOWN_COLUMNS;
   localparam int PAD_COLS  = (COLUMNS > SHOWN) ? COLUMNS : SHOWN;
   localparam int PAD_W     = PAD_COLS * LEVEL_W;

   logic [LINE_W-1:0] pix_store_ff  [ROWS];
   logic [LINE_W-1:0] disp_store_ff [ROWS];

   logic [7:0]           byte_ff;
   logic [PTR_ROW_W-1:0] wr_row_ff, wr_row_in;
   logic [COL_W-1:0]     wr_col_ff, wr_col_in;
   logic [ROW_W-1:0]     sweep_ff, sweep_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [7:0]           row_sel_ff, row_sel_in;
   logic [LINE_W-1:0]    pix_rd_ff;
   logic [LINE_W-1:0]    disp_rd_ff;
   logic                 strobe_ff;
   logic [7:0]           row_drive_ff;
   logic [7:0]           col0_ff, col1_ff, col2_ff;

   logic                 col_last;
   logic [ROW_W-1:0]     row_next;
   logic [LEVEL_W-1:0]   new_level;
   logic [LINE_W-1:0]    line_mod;
   logic [ROW_W-1:0]     pix_raddr;
   logic [ROW_W-1:0]     pix_waddr;
   logic [LINE_W-1:0]    pix_wdata;
   logic                 pix_we;
   logic                 disp_we;
   logic [LINE_W-1:0]    disp_wdata;
   logic [PAD_W-1:0]     padded;
   logic [SHOWN-1:0]     col_on;

   assign col_last = (wr_col_ff == COL_W'(COLUMNS - 1));

   assign status.ptr_end    = (wr_row_ff == PTR_ROW_W'(ROWS));
   assign status.ptr_last   = (wr_row_ff == PTR_ROW_W'(ROWS - 1)) && col_last;
   assign status.sweep_last = (sweep_ff == ROW_W'(ROWS - 1));

   // Level of the pixel being written: low or high field of the byte.
   always_comb begin
      if (cmd.sel_high) begin
         new_level = LEVEL_W'((byte_ff & rgbmx_pkg::HIGH_PIX_MASK) >> LEVEL_W);
      end else begin
         new_level = LEVEL_W'(byte_ff & rgbmx_pkg::LOW_PIX_MASK);
      end
   end

   // Merge the new level into the row that was read.
   always_comb begin
      line_mod = pix_rd_ff;
      for (int c = 0; c < COLUMNS; c++) begin
         if (wr_col_ff == COL_W'(c)) begin
            line_mod[c*LEVEL_W +: LEVEL_W] = new_level;
         end
      end
   end

   assign pix_raddr  = cmd.pix_read_wr ? wr_row_ff[ROW_W-1:0] : sweep_ff;
   assign pix_we     = cmd.pix_write | cmd.clear_row;
   assign pix_waddr  = cmd.clear_row ? sweep_ff : wr_row_ff[ROW_W-1:0];
   assign pix_wdata  = cmd.clear_row ? '0 : line_mod;
   assign disp_we    = cmd.clear_row | cmd.copy_row;
   assign disp_wdata = cmd.clear_row ? '0 : pix_rd_ff;

   // Next pointer, sweep and scan values.
   always_comb begin
      wr_row_in = wr_row_ff;
      wr_col_in = wr_col_ff;
      if (cmd.ptr_clear) begin
         wr_row_in = '0;
         wr_col_in = '0;
      end else if (cmd.pix_write) begin
         if (col_last) begin
            wr_col_in = '0;
            wr_row_in = wr_row_ff + 1'b1;
         end else begin
            wr_col_in = wr_col_ff + 1'b1;
         end
      end

      sweep_in = sweep_ff;
      if (cmd.clear_row | cmd.copy_row) begin
         sweep_in = status.sweep_last ? '0 : sweep_ff + 1'b1;
      end

      row_next = (row_ff == ROW_W'(ROWS - 1)) ? '0 : row_ff + 1'b1;
      step_in    = step_ff;
      row_in     = row_ff;
      row_sel_in = row_sel_ff;
      if (cmd.tick_adv) begin
         step_in = step_ff + 1'b1;
         if (step_ff == rgbmx_pkg::STEP_LAST) begin
            row_in = row_next;
            if (32'(row_next) < 32'(rgbmx_pkg::GROUP_W)) begin
               row_sel_in = ~(8'd1 << row_next);
            end else begin
               row_sel_in = rgbmx_pkg::ROWS_OFF;
            end
         end
      end
   end

   // Column comparators; columns past the store read as level zero.
   always_comb begin
      padded = PAD_W'(disp_rd_ff);
      for (int i = 0; i < SHOWN; i++) begin
         col_on[i] = (padded[i*LEVEL_W +: LEVEL_W] > LEVEL_W'(step_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_row_ff  <= '0;
         wr_col_ff  <= '0;
         sweep_ff   <= '0;
         row_ff     <= '0;
         step_ff    <= '0;
         row_sel_ff <= rgbmx_pkg::ROWS_OFF;
         strobe_ff  <= 1'b0;
      end else begin
         wr_row_ff  <= wr_row_in;
         wr_col_ff  <= wr_col_in;
         sweep_ff   <= sweep_in;
         row_ff     <= row_in;
         step_ff    <= step_in;
         row_sel_ff <= row_sel_in;
         strobe_ff  <= cmd.show;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         byte_ff <= rx_byte;
      end
      if (cmd.show) begin
         row_drive_ff <= row_sel_ff;
         col0_ff      <= col_on[7:0];
         col1_ff      <= col_on[15:8];
         col2_ff      <= col_on[23:16];
      end
   end

   // Stores: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (cmd.pix_read_wr | cmd.pix_read_sweep) begin
         pix_rd_ff <= pix_store_ff[pix_raddr];
      end
      if (pix_we) begin
         pix_store_ff[pix_waddr] <= pix_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.disp_fetch) begin
         disp_rd_ff <= disp_store_ff[row_ff];
      end
      if (disp_we) begin
         disp_store_ff[sweep_ff] <= disp_wdata;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_row_drive  = row_drive_ff;
   assign rsp_col_group0 = col0_ff;
   assign rsp_col_group1 = col1_ff;
   assign rsp_col_group2 = col2_ff;

endmodule

// ----- sv/rgbmx_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB matrix scan driver controller
// Decodes each item and sequences the datapath through pixel writes, store
// sweeps and scan ticks.
// ----------------------------------------------------------------------------
module rgbmx_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  operation,
   input  logic [7:0]            rx_byte,
   input  rgbmx_pkg::status_type status,
   output rgbmx_pkg::cmd_type    cmd,
   output logic                  busy
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_CLEAR    = 8'b0000_0010,
      ST_COPY_RD  = 8'b0000_0100,
      ST_COPY_WR  = 8'b0000_1000,
      ST_PIX_RD   = 8'b0001_0000,
      ST_PIX_WR   = 8'b0010_0000,
      ST_TK_FETCH = 8'b0100_0000,
      ST_TK_SHOW  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      half_ff, half_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      half_in  = half_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (operation) begin
                  cmd.tick_adv = 1'b1;
                  state_in     = ST_TK_FETCH;
               end else if ((rx_byte & rgbmx_pkg::DATA_FLAG) == 8'h00) begin
                  if (!status.ptr_end) begin
                     cmd.load_byte = 1'b1;
                     half_in       = 1'b0;
                     state_in      = ST_PIX_RD;
                  end
               end else if (rx_byte == rgbmx_pkg::CMD_CLEAR) begin
                  cmd.ptr_clear = 1'b1;
                  state_in      = ST_CLEAR;
               end else if (rx_byte == rgbmx_pkg::CMD_SHOW) begin
                  cmd.ptr_clear = 1'b1;
                  state_in      = ST_COPY_RD;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clear_row = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_COPY_RD: begin
            cmd.pix_read_sweep = 1'b1;
            state_in           = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            cmd.copy_row = 1'b1;
            state_in     = status.sweep_last ? ST_IDLE : ST_COPY_RD;
         end
         ST_PIX_RD: begin
            cmd.pix_read_wr = 1'b1;
            state_in        = ST_PIX_WR;
         end
         ST_PIX_WR: begin
            cmd.pix_write = 1'b1;
            cmd.sel_high  = half_ff;
            if (!half_ff && !status.ptr_last) begin
               half_in  = 1'b1;
               state_in = ST_PIX_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TK_FETCH: begin
            cmd.disp_fetch = 1'b1;
            state_in       = ST_TK_SHOW;
         end
         ST_TK_SHOW: begin
            cmd.show = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // After reset both stores are swept to zero before the first item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         half_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         half_ff  <= half_in;
      end
   end

endmodule

// ----- sv/rgb_matrix_pwm_scan_driver_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB matrix PWM scan driver
// Multiplexed PWM scan driver for an LED matrix with a 3-bit level per pixel.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; each tick item gives
// one result, shown for a single cycle with rsp_strobe high, and the receiver
// cannot stall it, so it must capture the result in that cycle. A tick
// advances the scan on acceptance, then reads the display row and then
// compares the levels for the strobe. A data byte writes one pixel, or two,
// each pixel a read-modify-write of one row of the pixel store. Command 0xFA
// sweeps ROWS rows, and command 0xFB copies row by row, each row a registered
// read of the pixel store and then a write of the display store. After reset
// a clearing pass zeroes both stores while busy stays high. Other bytes, and
// data bytes once the store is full, leave the controller idle and give no
// result.
// The pixel and display stores hold one row per word. Columns beyond 24 are
// kept but not shown; missing columns read as level zero. Rows from eight
// upward leave all row drive bits high.
// ----------------------------------------------------------------------------
module rgb_matrix_pwm_scan_driver_core #(
   parameter int ROWS    = rgbmx_pkg::ROWS_DEFAULT,
   parameter int COLUMNS = rgbmx_pkg::COLUMNS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_operation,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_strobe,
   output logic [7:0] rsp_row_drive,
   output logic [7:0] rsp_col_group0,
   output logic [7:0] rsp_col_group1,
   output logic [7:0] rsp_col_group2
);

   rgbmx_pkg::cmd_type    cmd;
   rgbmx_pkg::status_type status;

   // The controller decodes the item at the port; the datapath latches the
   // byte in the same cycle for the pixel writes that follow.
   rgbmx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_operation),
      .rx_byte   (req_rx_byte),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   rgbmx_datapath #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .rx_byte        (req_rx_byte),
      .rsp_strobe     (rsp_strobe),
      .rsp_row_drive  (rsp_row_drive),
      .rsp_col_group0 (rsp_col_group0),
      .rsp_col_group1 (rsp_col_group1),
      .rsp_col_group2 (rsp_col_group2)
   );

`ifndef SYNTHESIS
   // Every result comes from an accepted tick item via the fetch and show states.
   a_strobe_from_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_operation, 3))
      else $error("result without a matching tick item");

   // Two results can never fall in adjacent cycles.
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results in adjacent cycles");

   // At most one row is ever driven.
   a_row_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($countones(~rsp_row_drive) <= 1))
      else $error("more than one row driven");

   // A pixel write never happens with the store already full.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.pix_write |-> !status.ptr_end)
      else $error("pixel write past the end of the store");
`endif

endmodule
